@@ rtl/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants of the buddy page allocator
// Page marks, status codes, and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package bpa_pkg;
    localparam int NUM_PAGES_DEF  = 64;
    localparam int NUM_ORDERS_DEF = 7;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam logic [1:0] MARK_INSIDE = 2'd0;
    localparam logic [1:0] MARK_FREE   = 2'd1;
    localparam logic [1:0] MARK_USED   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TOO_BIG = 2'd1;
    localparam logic [1:0] ST_NO_MEM  = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // datapath operation codes
    localparam logic [3:0] DP_NOP      = 4'd0;
    localparam logic [3:0] DP_INIT     = 4'd1;  // write initial decomposition entry
    localparam logic [3:0] DP_RD_SCAN  = 4'd2;  // read entry at scan pointer
    localparam logic [3:0] DP_SPLIT    = 4'd3;  // write split half
    localparam logic [3:0] DP_USE      = 4'd4;  // mark block allocated
    localparam logic [3:0] DP_RD_FREE  = 4'd5;  // read flag at free page
    localparam logic [3:0] DP_REL      = 4'd6;  // release block
    localparam logic [3:0] DP_RD_BUD   = 4'd7;  // read buddy
    localparam logic [3:0] DP_MERGE    = 4'd8;  // clear upper of the pair
    localparam logic [3:0] DP_MERGE2   = 4'd9;

    typedef struct packed {
        logic [3:0]  op;
        logic [11:0] addr;
        logic [3:0]  ord;
        logic [1:0]  mark;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] mark;
        logic [3:0] ord;
        logic       aflag;
        logic [3:0] aord;
    } t_dp_sts;
endpackage
`default_nettype wire

@@ rtl/bpa_datapath.sv @@
// ----------------------------------------------------------------------------
// bpa_datapath: page tables of the buddy allocator
// Holds page order, page mark, allocation order and allocated flag in memories
// with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bpa_datapath #(
    parameter int NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF,
    parameter int NUM_ORDERS = bpa_pkg::NUM_ORDERS_DEF
) (
    input  wire              i_clk,
    input  wire bpa_pkg::t_dp_cmd i_cmd,
    output bpa_pkg::t_dp_sts o_sts
);
    localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int OW = $clog2(NUM_ORDERS);

    logic [1:0]    r_mark  [NUM_PAGES];
    logic [OW-1:0] r_ord   [NUM_PAGES];
    logic [OW-1:0] r_aord  [NUM_PAGES];
    logic          r_aflag [NUM_PAGES];
    bpa_pkg::t_dp_sts r_sts;

    logic [AW-1:0] w_a;
    logic [OW-1:0] w_o;
    assign w_a = i_cmd.addr[AW-1:0];
    assign w_o = i_cmd.ord[OW-1:0];

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            bpa_pkg::DP_INIT, bpa_pkg::DP_SPLIT, bpa_pkg::DP_MERGE2: begin
                r_mark[w_a] <= i_cmd.mark;
                r_ord[w_a]  <= w_o;
                if (i_cmd.op == bpa_pkg::DP_INIT) begin
                    r_aflag[w_a] <= 1'b0;
                    r_aord[w_a]  <= '0;
                end
            end
            bpa_pkg::DP_USE: begin
                r_mark[w_a]  <= bpa_pkg::MARK_USED;
                r_ord[w_a]   <= w_o;
                r_aord[w_a]  <= w_o;
                r_aflag[w_a] <= 1'b1;
            end
            bpa_pkg::DP_REL: begin
                r_mark[w_a]  <= bpa_pkg::MARK_FREE;
                r_ord[w_a]   <= w_o;
                r_aord[w_a]  <= '0;
                r_aflag[w_a] <= 1'b0;
            end
            bpa_pkg::DP_MERGE: begin
                r_mark[w_a] <= bpa_pkg::MARK_INSIDE;
                r_ord[w_a]  <= '0;
            end
            default: begin
            end
        endcase
        r_sts.mark  <= r_mark[w_a];
        r_sts.ord   <= 4'(r_ord[w_a]);
        r_sts.aflag <= r_aflag[w_a];
        r_sts.aord  <= 4'(r_aord[w_a]);
    end

    assign o_sts = r_sts;
endmodule
`default_nettype wire

@@ rtl/bpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpa_ctrl: sequencer of the buddy page allocator
// Builds the initial decomposition, then scans, splits, frees and merges one
// table access per cycle, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module bpa_ctrl #(
    parameter int NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF,
    parameter int NUM_ORDERS = bpa_pkg::NUM_ORDERS_DEF,
    parameter int PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire         i_op,
    input  wire  [31:0] i_size_bytes,
    input  wire  [5:0]  i_page_index,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [5:0]  o_start_page,
    output logic [2:0]  o_block_order,
    output logic [1:0]  o_status,
    output bpa_pkg::t_dp_cmd o_cmd,
    input  wire bpa_pkg::t_dp_sts i_sts
);
    localparam int PW  = $clog2(NUM_PAGES + 1);
    localparam int PBS = $clog2(PAGE_BYTES);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_SCHK  = 4'd3;
    localparam logic [3:0] S_SPLIT = 4'd4;
    localparam logic [3:0] S_USE   = 4'd5;
    localparam logic [3:0] S_FRD   = 4'd6;
    localparam logic [3:0] S_FCHK  = 4'd7;
    localparam logic [3:0] S_BRD   = 4'd8;
    localparam logic [3:0] S_BCHK  = 4'd9;
    localparam logic [3:0] S_MRG2  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]    r_state, n_state;
    logic [PW-1:0] r_ptr, n_ptr;     // scan / init pointer
    logic [3:0]    r_want, n_want;   // wanted order
    logic [3:0]    r_j, n_j;         // order being searched / split
    logic [PW-1:0] r_cur, n_cur;     // current block base
    logic [3:0]    r_k, n_k;
    logic [5:0]    r_pg, n_pg;
    logic [2:0]    r_bo, n_bo;
    logic [1:0]    r_st, n_st;
    logic          r_ov, n_ov;
    logic [5:0]    r_fpage, n_fpage;

    // order of the incoming size: index of top set bit of size/PAGE_BYTES
    logic [31:0] w_q;
    logic [5:0]  w_ord;
    always_comb begin
        w_q   = i_size_bytes >> PBS;
        w_ord = '0;
        for (int b = 1; b < 32; b++) begin
            if (w_q[b]) w_ord = 6'(b);
        end
    end

    // greedy initial block order for remaining pages
    logic [PW-1:0] w_left;
    logic [3:0]    w_iord;
    always_comb begin
        w_left = PW'(NUM_PAGES) - r_ptr;
        w_iord = '0;
        for (int b = 1; b < NUM_ORDERS; b++) begin
            if ((PW+1)'(1) << b <= (PW+1)'(w_left)) w_iord = 4'(b);
        end
    end

    logic [PW:0] w_bud;
    assign w_bud = (PW+1)'(r_cur ^ (PW'(1) << r_k));

    always_comb begin
        n_state = r_state; n_ptr = r_ptr; n_want = r_want; n_j = r_j;
        n_cur = r_cur; n_k = r_k; n_pg = r_pg; n_bo = r_bo; n_st = r_st;
        n_ov = r_ov; n_fpage = r_fpage;
        o_cmd = '0;
        o_cmd.op = bpa_pkg::DP_NOP;
        if (r_ov && i_ready) n_ov = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.op   = bpa_pkg::DP_INIT;
                o_cmd.addr = 12'(r_ptr);
                // fill: heads get free mark, others inside; walk each page
                if (r_ptr == r_cur) begin
                    o_cmd.mark = bpa_pkg::MARK_FREE;
                    o_cmd.ord  = w_iord;
                    n_cur      = r_cur + (PW'(1) << w_iord);
                end else begin
                    o_cmd.mark = bpa_pkg::MARK_INSIDE;
                    o_cmd.ord  = '0;
                end
                n_ptr = r_ptr + 1'b1;
                if (r_ptr == PW'(NUM_PAGES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid && !r_ov) begin
                    if (i_op == bpa_pkg::OP_ALLOC) begin
                        if (w_ord >= 6'(NUM_ORDERS)) begin
                            n_pg = '0; n_bo = '0; n_st = bpa_pkg::ST_TOO_BIG;
                            n_state = S_OUT;
                        end else begin
                            n_want = 4'(w_ord); n_j = 4'(w_ord);
                            n_ptr = '0; n_state = S_SCAN;
                        end
                    end else begin
                        n_fpage = i_page_index;
                        if (7'(i_page_index) >= 7'(NUM_PAGES)) begin
                            n_pg = i_page_index; n_bo = '0; n_st = bpa_pkg::ST_BAD;
                            n_state = S_OUT;
                        end else begin
                            n_state = S_FRD;
                        end
                    end
                end
            end
            S_SCAN: begin
                o_cmd.op = bpa_pkg::DP_RD_SCAN; o_cmd.addr = 12'(r_ptr);
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (i_sts.mark == bpa_pkg::MARK_FREE && i_sts.ord == r_j) begin
                    n_cur = r_ptr; n_state = (r_j == r_want) ? S_USE : S_SPLIT;
                end else if (r_ptr == PW'(NUM_PAGES - 1)) begin
                    n_ptr = '0;
                    if (r_j == 4'(NUM_ORDERS - 1)) begin
                        n_pg = '0; n_bo = '0; n_st = bpa_pkg::ST_NO_MEM;
                        n_state = S_OUT;
                    end else begin
                        n_j = r_j + 1'b1; n_state = S_SCAN;
                    end
                end else begin
                    n_ptr = r_ptr + 1'b1; n_state = S_SCAN;
                end
            end
            S_SPLIT: begin
                // upper half of order j-1 becomes free
                o_cmd.op   = bpa_pkg::DP_SPLIT;
                o_cmd.addr = 12'(r_cur + (PW'(1) << (r_j - 1'b1)));
                o_cmd.mark = bpa_pkg::MARK_FREE;
                o_cmd.ord  = r_j - 1'b1;
                n_j = r_j - 1'b1;
                if (r_j - 1'b1 == r_want) n_state = S_USE;
            end
            S_USE: begin
                o_cmd.op = bpa_pkg::DP_USE; o_cmd.addr = 12'(r_cur);
                o_cmd.ord = r_want;
                n_pg = 6'(r_cur); n_bo = 3'(r_want); n_st = bpa_pkg::ST_OK;
                n_state = S_OUT;
            end
            S_FRD: begin
                o_cmd.op = bpa_pkg::DP_RD_FREE; o_cmd.addr = 12'(r_fpage);
                n_state = S_FCHK;
            end
            S_FCHK: begin
                if (!i_sts.aflag) begin
                    n_pg = r_fpage; n_bo = '0; n_st = bpa_pkg::ST_BAD;
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = bpa_pkg::DP_REL; o_cmd.addr = 12'(r_fpage);
                    o_cmd.ord = i_sts.aord;
                    n_pg = r_fpage; n_bo = 3'(i_sts.aord); n_st = bpa_pkg::ST_OK;
                    n_cur = PW'(r_fpage); n_k = i_sts.aord;
                    n_state = S_BRD;
                end
            end
            S_BRD: begin
                if (r_k + 1'b1 >= 4'(NUM_ORDERS) ||
                    w_bud + ((PW+1)'(1) << r_k) > (PW+1)'(NUM_PAGES)) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = bpa_pkg::DP_RD_BUD; o_cmd.addr = 12'(w_bud);
                    n_state = S_BCHK;
                end
            end
            S_BCHK: begin
                if (i_sts.mark != bpa_pkg::MARK_FREE || i_sts.ord != r_k) begin
                    n_state = S_OUT;
                end else begin
                    // clear the upper of the pair
                    o_cmd.op   = bpa_pkg::DP_MERGE;
                    o_cmd.addr = 12'(r_cur | (PW'(1) << r_k));
                    n_cur = r_cur & ~(PW'(1) << r_k);
                    n_state = S_MRG2;
                end
            end
            S_MRG2: begin
                o_cmd.op = bpa_pkg::DP_MERGE2; o_cmd.addr = 12'(r_cur);
                o_cmd.mark = bpa_pkg::MARK_FREE; o_cmd.ord = r_k + 1'b1;
                n_k = r_k + 1'b1;
                n_state = S_BRD;
            end
            S_OUT: begin
                n_ov = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ptr   <= '0;
            r_cur   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_cur   <= n_cur;
            r_ov    <= n_ov;
        end
        r_want <= n_want; r_j <= n_j; r_k <= n_k; r_pg <= n_pg;
        r_bo <= n_bo; r_st <= n_st; r_fpage <= n_fpage;
    end

    assign o_ready       = (r_state == S_IDLE) && !r_ov;
    assign o_valid       = r_ov;
    assign o_start_page  = r_pg;
    assign o_block_order = r_bo;
    assign o_status      = r_st;
endmodule
`default_nettype wire

@@ rtl/buddy_page_allocator.sv @@
// ----------------------------------------------------------------------------
// buddy_page_allocator: buddy allocator over a fixed page pool
// Top level joining the sequencer and the page tables.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_ready carries an item: i_op (0 allocate, 1 free),
// i_size_bytes and i_page_index. Output channel o_valid/i_ready returns one
// item per input: o_start_page, o_block_order, o_status.
// After reset the block writes the initial free-block layout, one page a
// cycle, with o_ready low.
// An allocate walks the page table once per candidate order, one page read at
// a time, then splits the found block down one order per split; a free reads
// the flag of its page, releases the block, then reads the buddy and merges
// once per merge level. The single table read port serialises these steps.
// One item is in flight at a time.
// The result sits in an output register; while the receiver stalls it holds
// and no new item is accepted.
// ----------------------------------------------------------------------------
`default_nettype none
module buddy_page_allocator #(
    parameter int NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF,
    parameter int NUM_ORDERS = bpa_pkg::NUM_ORDERS_DEF,
    parameter int PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire         i_op,
    input  wire  [31:0] i_size_bytes,
    input  wire  [5:0]  i_page_index,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [5:0]  o_start_page,
    output logic [2:0]  o_block_order,
    output logic [1:0]  o_status
);
    bpa_pkg::t_dp_cmd w_cmd;
    bpa_pkg::t_dp_sts w_sts;

    bpa_ctrl #(.NUM_PAGES(NUM_PAGES), .NUM_ORDERS(NUM_ORDERS),
               .PAGE_BYTES(PAGE_BYTES)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_op, .i_size_bytes,
        .i_page_index, .o_valid, .i_ready, .o_start_page, .o_block_order,
        .o_status, .o_cmd(w_cmd), .i_sts(w_sts)
    );

    bpa_datapath #(.NUM_PAGES(NUM_PAGES), .NUM_ORDERS(NUM_ORDERS)) u_dp (
        .i_clk, .i_cmd(w_cmd), .o_sts(w_sts)
    );

    a_no_accept_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("accept while result pending");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result dropped");
    a_ok_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != bpa_pkg::ST_OK |-> o_block_order == 3'd0)
        else $error("order on failure");
endmodule
`default_nettype wire
